### rtl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and constants of the bounded FIFO with search
// Action and status codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bfs_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned CAP_W     = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 3;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_LIST   = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FOUND   = 3'd3,
    ST_MISSING = 3'd4,
    ST_LISTED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch action and value
    logic enq;         // run enqueue
    logic deq;         // run dequeue
    logic short_done;  // search/list on an empty queue
    logic walk_start;  // issue read of the oldest entry
    logic walk_step;   // consume one read entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e action;
    logic    empty;
    logic    walk_last;
  } stat_t;

endpackage

`default_nettype wire

### rtl/bfs_ram.sv
// ----------------------------------------------------------------------------
// bfs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bfs_ctrl.sv
// ----------------------------------------------------------------------------
// bfs_ctrl: operation sequencer
// Takes an item, runs enqueue/dequeue in one step, or walks the stored
// entries one per cycle for search and list.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire bfs_pkg::stat_t stat_i,
  output bfs_pkg::cmd_t       cmd_o
);

  bfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      bfs_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = bfs_pkg::S_EXEC;
        end
      end
      bfs_pkg::S_EXEC: begin
        unique case (stat_i.action)
          bfs_pkg::ACT_ENQ: begin
            cmd_o.enq = 1'b1;
            state_d   = bfs_pkg::S_IDLE;
          end
          bfs_pkg::ACT_DEQ: begin
            cmd_o.deq = 1'b1;
            state_d   = bfs_pkg::S_IDLE;
          end
          default: begin
            if (stat_i.empty) begin
              cmd_o.short_done = 1'b1;
              state_d          = bfs_pkg::S_IDLE;
            end else begin
              cmd_o.walk_start = 1'b1;
              state_d          = bfs_pkg::S_WALK;
            end
          end
        endcase
      end
      bfs_pkg::S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = bfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/bfs_dp.sv
// ----------------------------------------------------------------------------
// bfs_dp: queue datapath
// Ring storage, head pointer, count, capacity register, walk counter,
// match logic and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_dp #(
  parameter int unsigned DEPTH = bfs_pkg::DEPTH_DEF,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bfs_pkg::cmd_t                 cmd_i,
  output bfs_pkg::stat_t                     stat_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic signed [bfs_pkg::VAL_W-1:0] value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bfs_pkg::CAP_W-1:0]     cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [bfs_pkg::STAT_W-1:0]         status_o,
  output logic signed [bfs_pkg::VAL_W-1:0]   element_o,
  output logic                               last_o,
  output logic [CntW-1:0]                    occupancy_o,
  output logic                               is_full_o,
  output logic                               is_empty_o
);

  localparam int unsigned CmpW = (CntW > bfs_pkg::CAP_W) ? CntW : bfs_pkg::CAP_W;

  // head + offset modulo DEPTH; both operands stay below or at DEPTH
  function automatic logic [PtrW-1:0] slot(input logic [PtrW-1:0] head,
                                           input logic [PtrW-1:0] off);
    logic [PtrW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (PtrW+1)'(DEPTH)) begin
      sum = sum - (PtrW+1)'(DEPTH);
    end
    return sum[PtrW-1:0];
  endfunction

  logic [bfs_pkg::CAP_W-1:0]  capacity_q;
  logic [PtrW-1:0]            head_q, head_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            idx_q;
  bfs_pkg::action_e           action_q;
  logic [bfs_pkg::VAL_W-1:0]  value_q;
  logic                       hit_q;

  logic                       res_valid_q;
  bfs_pkg::status_e           res_status_q;
  logic [bfs_pkg::VAL_W-1:0]  res_elem_q;
  logic                       res_last_q;
  logic [CntW-1:0]            res_occ_q;
  logic                       res_full_q;
  logic                       res_empty_q;

  logic                       emit;
  bfs_pkg::status_e           status_n;
  logic [bfs_pkg::VAL_W-1:0]  elem_n;
  logic                       last_n;

  logic [CmpW-1:0]            cap_ext, eff_cap;
  logic                       full_now, empty_now, walk_last, match;
  logic [CntW-1:0]            idx_inc;
  logic                       ram_we;
  logic [PtrW-1:0]            ram_waddr, ram_raddr;
  logic [bfs_pkg::VAL_W-1:0]  ram_rdata;

  assign cap_ext   = CmpW'(capacity_q);
  assign eff_cap   = (cap_ext > CmpW'(DEPTH)) ? CmpW'(DEPTH) : cap_ext;
  assign full_now  = CmpW'(count_q) >= eff_cap;
  assign empty_now = (count_q == '0);
  assign idx_inc   = idx_q + CntW'(1);
  assign walk_last = (idx_inc == count_q);
  assign match     = (ram_rdata == value_q);

  assign ram_waddr = slot(head_q, count_q[PtrW-1:0]);
  // during a walk, read one entry ahead of the one being consumed
  assign ram_raddr = cmd_i.walk_start ? head_q : slot(head_q, idx_inc[PtrW-1:0]);

  bfs_ram #(
    .WIDTH (bfs_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d  = count_q;
    head_d   = head_q;
    ram_we   = 1'b0;
    emit     = 1'b0;
    status_n = bfs_pkg::ST_OK;
    elem_n   = '0;
    last_n   = 1'b1;
    if (cmd_i.enq) begin
      emit = 1'b1;
      if (full_now) begin
        status_n = bfs_pkg::ST_FULL;
      end else begin
        ram_we  = 1'b1;
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.deq) begin
      emit = 1'b1;
      if (empty_now) begin
        status_n = bfs_pkg::ST_EMPTY;
      end else begin
        head_d  = slot(head_q, PtrW'(1));
        count_d = count_q - CntW'(1);
      end
    end
    if (cmd_i.short_done) begin
      emit     = 1'b1;
      status_n = (action_q == bfs_pkg::ACT_SEARCH) ? bfs_pkg::ST_MISSING
                                                   : bfs_pkg::ST_EMPTY;
    end
    if (cmd_i.walk_step) begin
      if (action_q == bfs_pkg::ACT_LIST) begin
        emit     = 1'b1;
        status_n = bfs_pkg::ST_LISTED;
        elem_n   = ram_rdata;
        last_n   = walk_last;
      end else if (walk_last) begin
        emit     = 1'b1;
        status_n = (hit_q || match) ? bfs_pkg::ST_FOUND : bfs_pkg::ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= bfs_pkg::CAP_RESET;
      head_q      <= '0;
      count_q     <= '0;
      action_q    <= bfs_pkg::ACT_ENQ;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      res_valid_q <= emit;
      if (cmd_i.load) begin
        action_q <= bfs_pkg::action_e'(action_i);
      end
      if (cmd_i.walk_start) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        idx_q <= idx_inc;
        hit_q <= hit_q | match;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
    end
    if (emit) begin
      res_status_q <= status_n;
      res_elem_q   <= elem_n;
      res_last_q   <= last_n;
      res_occ_q    <= count_d;
      res_full_q   <= CmpW'(count_d) >= eff_cap;
      res_empty_q  <= (count_d == '0);
    end
  end

  assign stat_o.action    = action_q;
  assign stat_o.empty     = empty_now;
  assign stat_o.walk_last = walk_last;

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign element_o      = res_elem_q;
  assign last_o         = res_last_q;
  assign occupancy_o    = res_occ_q;
  assign is_full_o      = res_full_q;
  assign is_empty_o     = res_empty_q;

endmodule

`default_nettype wire

### rtl/bounded_fifo_with_search_top.sv
// Enqueue/dequeue: busy only in S_EXEC; the result is registered and strobed after S_EXEC.
// Search/list over n entries: busy through S_EXEC and S_WALK, one storage read per cycle from
// the single RAM read port; list results appear one per cycle.
// A new item is taken in the cycle its predecessor's last result is shown.
// Reset: queue empty, head at slot 0, capacity 5; storage contents undefined.
// ----------------------------------------------------------------------------
// bounded_fifo_with_search_top: bounded FIFO with search and list
// Sequencer plus datapath; results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_fifo_with_search_top #(
  parameter int unsigned DEPTH = bfs_pkg::DEPTH_DEF,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       action_i,
  input  wire logic signed [bfs_pkg::VAL_W-1:0] value_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [bfs_pkg::CAP_W-1:0]        cfg_wdata_i,
  output logic                                  result_valid_o,
  output logic [bfs_pkg::STAT_W-1:0]            status_o,
  output logic signed [bfs_pkg::VAL_W-1:0]      element_o,
  output logic                                  last_o,
  output logic [CntW-1:0]                       occupancy_o,
  output logic                                  is_full_o,
  output logic                                  is_empty_o
);

  bfs_pkg::cmd_t  cmd;
  bfs_pkg::stat_t stat;

  bfs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  bfs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .element_o      (element_o),
    .last_o         (last_o),
    .occupancy_o    (occupancy_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted but sequencer not busy");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("final result while sequencer still busy");

  a_listed_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == bfs_pkg::ST_LISTED) |-> !is_empty_o)
    else $error("listed entry from an empty queue");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (occupancy_o <= CntW'(DEPTH)))
    else $error("occupancy above storage depth");

endmodule

`default_nettype wire
